>>> hdl/frcal_pkg.sv
// Package for the flash read timing calibration block.
// Holds the training pattern, sweep limits, the result struct and the divide clamp.
// No dependencies; used by frcal_core and the top level.
`default_nettype none

package frcal_pkg;

  localparam int PATTERN_LEN = 8;
  localparam int MAX_TRIALS  = 24;
  localparam int MIN_PASSES  = 5;

  localparam int POS_W   = 3;
  localparam int TRIAL_W = 5;
  localparam int SET_W   = 6;
  localparam int DIV_W   = 3;

  // largest usable divide: six trials per divide step
  localparam int DIV_CAP_RAW = MAX_TRIALS / 6;
  localparam int DIV_CAP     = (DIV_CAP_RAW > 4) ? 4 : ((DIV_CAP_RAW < 1) ? 1 : DIV_CAP_RAW);

  localparam logic [DIV_W-1:0]   DIVIDE_RESET = 3'd3;
  localparam logic [POS_W-1:0]   LAST_POS     = POS_W'(PATTERN_LEN - 1);
  localparam logic [TRIAL_W-1:0] TRIAL_LAST   = TRIAL_W'(MAX_TRIALS);
  localparam logic [TRIAL_W-1:0] PASS_MIN     = TRIAL_W'(MIN_PASSES);

  // configuration register index (paddr[2])
  localparam logic CFG_IDX_CLOCK_DIVIDE = 1'b0;

  localparam logic [31:0] TRAIN_PATTERN [8] = '{
    32'h0f0f00ff, 32'h0f0f0f0f, 32'h00ff00ff, 32'h00ff00ff,
    32'h08cef731, 32'h08cef731, 32'h639c639c, 32'h639c639c
  };

  typedef struct packed {
    logic [1:0]         read_adjust;
    logic               falling_edge;
    logic [1:0]         capture_delay;
    logic               sweep_done;
    logic               calibrated_ok;
    logic [TRIAL_W-1:0] pass_total;
  } result_t;

  // pad delay start value: clamped divide minus one
  function automatic logic [1:0] init_delay(input logic [DIV_W-1:0] divide);
    logic [DIV_W-1:0] d;
    d = divide;
    if (d < DIV_W'(1)) d = DIV_W'(1);
    if (d > DIV_W'(DIV_CAP)) d = DIV_W'(DIV_CAP);
    d = d - DIV_W'(1);
    return d[1:0];
  endfunction

endpackage

`default_nettype wire

>>> hdl/frcal_core.sv
// Sweep state, trial compare, setting table and final choice.
// Uses frcal_pkg; instantiated by flash_read_timing_calibration_unit.
`default_nettype none

module frcal_core (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       restart,
  input  wire logic [frcal_pkg::DIV_W-1:0] restart_divide,
  input  wire logic [frcal_pkg::DIV_W-1:0] divide,
  input  wire logic                       step,
  input  wire logic [31:0]                word,
  output logic                            trial_end,
  output frcal_pkg::result_t              result
);

  logic [frcal_pkg::POS_W-1:0]   word_position, word_position_next;
  logic                          trial_all_match, trial_all_match_next;
  logic [1:0]                    adjust_counter, adjust_counter_next;
  logic                          edge_counter, edge_counter_next;
  logic [1:0]                    delay_counter, delay_counter_next;
  logic [frcal_pkg::TRIAL_W-1:0] trial_index, trial_index_next;
  logic [frcal_pkg::TRIAL_W-1:0] pass_counter, pass_counter_next;
  logic [frcal_pkg::TRIAL_W-1:0] first_pass_index, first_pass_index_next;

  logic [frcal_pkg::SET_W-1:0] setting_table [frcal_pkg::MAX_TRIALS];

  logic                          all_match;
  logic                          sweep_last;
  logic [frcal_pkg::SET_W-1:0]   setting;
  logic [frcal_pkg::TRIAL_W:0]   best;
  logic [frcal_pkg::SET_W-1:0]   chosen_setting;
  logic                          table_wr;

  assign trial_end = (word_position == frcal_pkg::LAST_POS);
  assign all_match = trial_all_match && (word == frcal_pkg::TRAIN_PATTERN[word_position]);
  assign setting   = {1'b0, delay_counter, adjust_counter, edge_counter};
  assign table_wr  = step && trial_end && (trial_index < frcal_pkg::TRIAL_LAST);

  always_comb begin
    word_position_next    = word_position;
    trial_all_match_next  = trial_all_match;
    adjust_counter_next   = adjust_counter;
    edge_counter_next     = edge_counter;
    delay_counter_next    = delay_counter;
    trial_index_next      = trial_index;
    pass_counter_next     = pass_counter;
    first_pass_index_next = first_pass_index;
    result                = '0;
    best                  = '0;
    chosen_setting        = '0;
    sweep_last            = 1'b0;

    if (!trial_end) begin
      word_position_next   = word_position + frcal_pkg::POS_W'(1);
      trial_all_match_next = all_match;
    end else begin
      word_position_next   = '0;
      trial_all_match_next = 1'b1;
      if (all_match) begin
        if (pass_counter == '0) first_pass_index_next = trial_index;
        pass_counter_next = pass_counter + frcal_pkg::TRIAL_W'(1);
      end
      trial_index_next = trial_index + frcal_pkg::TRIAL_W'(1);
      sweep_last = (adjust_counter >= 2'd2 && edge_counter && delay_counter == 2'd0) ||
                   (trial_index_next >= frcal_pkg::TRIAL_LAST);
      result.pass_total = pass_counter_next;

      if (!sweep_last) begin
        if (delay_counter != 2'd0) begin
          delay_counter_next = delay_counter - 2'd1;
        end else begin
          delay_counter_next = frcal_pkg::init_delay(divide);
          if (!edge_counter) begin
            edge_counter_next = 1'b1;
          end else begin
            edge_counter_next   = 1'b0;
            adjust_counter_next = adjust_counter + 2'd1;
          end
        end
        result.read_adjust   = adjust_counter_next;
        result.falling_edge  = edge_counter_next;
        result.capture_delay = delay_counter_next;
      end else begin
        result.sweep_done = 1'b1;
        if (pass_counter_next >= frcal_pkg::PASS_MIN) begin
          // middle of the passing window; always an earlier trial of this sweep
          best = {1'b0, first_pass_index_next} + {2'b0, pass_counter_next[frcal_pkg::TRIAL_W-1:1]};
          if (best < (frcal_pkg::TRIAL_W+1)'(frcal_pkg::MAX_TRIALS))
            chosen_setting = setting_table[best[frcal_pkg::TRIAL_W-1:0]];
          result.read_adjust   = chosen_setting[2:1];
          result.falling_edge  = chosen_setting[0];
          result.capture_delay = chosen_setting[4:3];
          result.calibrated_ok = 1'b1;
        end
        word_position_next    = '0;
        trial_all_match_next  = 1'b1;
        adjust_counter_next   = '0;
        edge_counter_next     = 1'b0;
        delay_counter_next    = frcal_pkg::init_delay(divide);
        trial_index_next      = '0;
        pass_counter_next     = '0;
        first_pass_index_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_position    <= '0;
      trial_all_match  <= 1'b1;
      adjust_counter   <= '0;
      edge_counter     <= 1'b0;
      delay_counter    <= frcal_pkg::init_delay(frcal_pkg::DIVIDE_RESET);
      trial_index      <= '0;
      pass_counter     <= '0;
      first_pass_index <= '0;
    end else if (restart) begin
      word_position    <= '0;
      trial_all_match  <= 1'b1;
      adjust_counter   <= '0;
      edge_counter     <= 1'b0;
      delay_counter    <= frcal_pkg::init_delay(restart_divide);
      trial_index      <= '0;
      pass_counter     <= '0;
      first_pass_index <= '0;
    end else if (step) begin
      word_position    <= word_position_next;
      trial_all_match  <= trial_all_match_next;
      adjust_counter   <= adjust_counter_next;
      edge_counter     <= edge_counter_next;
      delay_counter    <= delay_counter_next;
      trial_index      <= trial_index_next;
      pass_counter     <= pass_counter_next;
      first_pass_index <= first_pass_index_next;
    end
  end

  always_ff @(posedge clk) begin
    if (table_wr) setting_table[trial_index] <= setting;
  end

endmodule

`default_nettype wire

>>> hdl/flash_read_timing_calibration_unit.sv
// Flash read timing calibration, top level: handshake, input and result registers,
// clock_divide register on an APB-style port. Uses frcal_pkg and frcal_core.
//
// Usage: each item on the input channel (in_valid/in_stall, read_word) is one word
// captured from the flash under the setting last emitted. Eight words make a trial.
// The last word of a trial yields one result item on the output channel
// (out_valid/out_stall): the next setting to program, or, after the last trial,
// the chosen setting with sweep_done set (calibrated_ok clear on failure).
// Throughput: one word per cycle while no trial result waits on a stalled receiver. A
// trial's last word passes the input register, then the result register, which loads as
// out_valid rises; all compare and update logic sits between them.
// When the receiver stalls, the result register holds; words that close no trial
// keep flowing, and one more word is held in the input register before in_stall
// rises. Reset clears the sweep, sets clock_divide to 3 and empties both registers.
// Writing clock_divide (byte address 0) restarts the sweep; write only when idle.
// After a final result the next word starts a new sweep.
`default_nettype none

module flash_read_timing_calibration_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] read_word,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       apply_read_adjust,
  output logic             apply_falling_edge,
  output logic [1:0]       apply_pad_delay,
  output logic             sweep_done,
  output logic             calibrated_ok,
  output logic [4:0]       pass_total,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [frcal_pkg::DIV_W-1:0] clock_divide;
  logic                        s1_valid;
  logic [31:0]                 s1_word;
  logic                        s1_go;
  logic                        trial_end;
  logic                        cfg_wr;
  logic                        reg_sel;
  frcal_pkg::result_t          core_result;
  frcal_pkg::result_t          res;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == frcal_pkg::CFG_IDX_CLOCK_DIVIDE);
  assign cfg_wr  = psel && penable && pwrite && pready && reg_sel;
  assign prdata  = reg_sel ? {{(32-frcal_pkg::DIV_W){1'b0}}, clock_divide} : 32'd0;

  // a word that closes no trial never needs the result register
  assign s1_go    = s1_valid && (!trial_end || !out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_divide <= frcal_pkg::DIVIDE_RESET;
      s1_valid     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wr) clock_divide <= pwdata[frcal_pkg::DIV_W-1:0];
      if (in_valid && !in_stall) s1_valid <= 1'b1;
      else if (s1_go) s1_valid <= 1'b0;
      if (s1_go && trial_end) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) s1_word <= read_word;
    if (s1_go && trial_end) res <= core_result;
  end

  frcal_core u_core (
    .clk            (clk),
    .rst            (rst),
    .restart        (cfg_wr),
    .restart_divide (pwdata[frcal_pkg::DIV_W-1:0]),
    .divide         (clock_divide),
    .step           (s1_go),
    .word           (s1_word),
    .trial_end      (trial_end),
    .result         (core_result)
  );

  assign apply_read_adjust  = res.read_adjust;
  assign apply_falling_edge = res.falling_edge;
  assign apply_pad_delay    = res.capture_delay;
  assign sweep_done         = res.sweep_done;
  assign calibrated_ok      = res.calibrated_ok;
  assign pass_total         = res.pass_total;

  a_stall_needs_word: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && trial_end && out_valid)
    else $error("input stalled without a pending trial result");

  a_ok_only_when_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && calibrated_ok |-> sweep_done)
    else $error("calibrated_ok set on an intermediate result");

  a_ok_needs_passes: assert property (@(posedge clk) disable iff (rst)
    out_valid && calibrated_ok |-> pass_total >= frcal_pkg::PASS_MIN)
    else $error("calibrated_ok with too few passing trials");

  a_adjust_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> apply_read_adjust <= 2'd2)
    else $error("read adjust out of range");

  a_result_from_trial: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_go && trial_end))
    else $error("result appeared without a finished trial");

endmodule

`default_nettype wire
